### hw/rtl/ctt_pkg.sv
// Shared types and character constants for the settings text tokenizer.
package ctt_pkg;

	localparam logic [7:0] CH_HASH          = 8'h23;
	localparam logic [7:0] CH_QUOTE         = 8'h22;
	localparam logic [7:0] CH_SPACE         = 8'h20;
	localparam logic [7:0] CH_FIRST_VISIBLE = 8'h21;
	localparam logic [7:0] CH_LAST_VISIBLE  = 8'h7E;
	localparam logic [7:0] CH_EQUALS        = 8'h3D;
	localparam logic [7:0] CH_CR            = 8'h0D;
	localparam logic [7:0] CH_LF            = 8'h0A;
	localparam logic [7:0] CH_NUL           = 8'h00;

	localparam int unsigned MaxResults = 3;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       final_byte;
	} text_beat_t;

	typedef struct packed {
		logic [7:0] token_byte;
		logic       list_end;
		logic       run_last;
	} tok_beat_t;

endpackage

### hw/rtl/config_text_tokenizer_top.sv
// Streaming tokenizer: settings text bytes in, zero-terminated token list out.
//
//  channel | direction | payload      | handshake
//  text    | in        | text_beat_t  | text_valid / text_ready
//  tok     | out       | tok_beat_t   | tok_valid / tok_ready
//
// One text byte is taken per cycle; it is decoded in the accepting cycle and
// its results (zero to three beats) land in a three-entry result register.
// A byte that yields at most one beat keeps the one-byte-per-cycle rate while
// tok is ready; a final byte that is itself a token byte yields three beats
// and holds off text while they drain. A stall on tok holds the result
// register and drops text_ready while a beat waits on it, and more than one
// waiting beat drops it too. Reset clears the comment, quote and open-token
// state and empties the result register.
module config_text_tokenizer_top
	import ctt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       text_valid,
	output logic       text_ready,
	input  text_beat_t text_beat,
	output logic       tok_valid,
	input  logic       tok_ready,
	output tok_beat_t  tok_beat
);

	typedef enum logic [1:0] {
		CM_TEXT,
		CM_LINE,
		CM_CRLF
	} cmode_t;

	cmode_t      cmode_q, cmode_d;
	logic        quote_q, quote_d;
	logic        open_q, open_d;

	tok_beat_t   res_q [MaxResults];
	logic [1:0]  rem_q;

	tok_beat_t   nres [MaxResults];
	logic [1:0]  ncnt;

	logic        text_fire;
	logic        tok_fire;
	logic        line_end;
	logic        visible;
	logic [7:0]  low_lim;
	logic [7:0]  c;

	assign c         = text_beat.text_byte;
	assign tok_valid = (rem_q != 2'd0);
	assign tok_beat  = res_q[0];
	assign tok_fire  = tok_valid & tok_ready;
	// accept while the buffer is empty or its last beat leaves this cycle
	assign text_ready = (rem_q == 2'd0) || ((rem_q == 2'd1) && tok_ready);
	assign text_fire  = text_valid & text_ready;

	assign line_end = (c == CH_CR) || (c == CH_LF);
	assign low_lim  = quote_q ? CH_SPACE : CH_FIRST_VISIBLE;

	always_comb begin
		cmode_d = cmode_q;
		quote_d = quote_q;
		open_d  = open_q;
		visible = 1'b0;
		ncnt    = 2'd0;
		for (int i = 0; i < MaxResults; i++) begin
			nres[i] = '{token_byte: CH_NUL, list_end: 1'b0, run_last: 1'b0};
		end

		if (cmode_q == CM_LINE) begin
			if (line_end) begin
				cmode_d = CM_CRLF;
			end
		end else if ((cmode_q == CM_CRLF) && line_end) begin
			cmode_d = CM_CRLF;
		end else begin
			cmode_d = CM_TEXT;
			if (c == CH_HASH) begin
				cmode_d = CM_LINE;
			end else if (c == CH_QUOTE) begin
				quote_d = ~quote_q;
			end else begin
				visible = !((c < low_lim) || (c > CH_LAST_VISIBLE) || (c == CH_EQUALS));
			end
			if (c != CH_HASH) begin
				if (visible) begin
					nres[ncnt] = '{token_byte: c, list_end: 1'b0, run_last: 1'b0};
					ncnt = ncnt + 2'd1;
					open_d = 1'b1;
				end else if (open_q) begin
					nres[ncnt] = '{token_byte: CH_NUL, list_end: 1'b0, run_last: 1'b0};
					ncnt = ncnt + 2'd1;
					open_d = 1'b0;
				end
			end
		end

		if (text_beat.final_byte) begin
			if (open_d) begin
				nres[ncnt] = '{token_byte: CH_NUL, list_end: 1'b0, run_last: 1'b0};
				ncnt = ncnt + 2'd1;
			end
			nres[ncnt] = '{token_byte: CH_NUL, list_end: 1'b1, run_last: 1'b0};
			ncnt = ncnt + 2'd1;
			// start the next text from scratch
			cmode_d = CM_TEXT;
			quote_d = 1'b0;
			open_d  = 1'b0;
		end

		if (ncnt != 2'd0) begin
			nres[ncnt - 2'd1].run_last = 1'b1;
		end
	end

	// advance the result register one beat per tok handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmode_q <= CM_TEXT;
			quote_q <= 1'b0;
			open_q  <= 1'b0;
			rem_q   <= 2'd0;
			for (int i = 0; i < MaxResults; i++) begin
				res_q[i] <= '0;
			end
		end else if (text_fire) begin
			cmode_q <= cmode_d;
			quote_q <= quote_d;
			open_q  <= open_d;
			rem_q   <= ncnt;
			for (int i = 0; i < MaxResults; i++) begin
				res_q[i] <= nres[i];
			end
		end else if (tok_fire) begin
			rem_q <= rem_q - 2'd1;
			for (int i = 0; i < MaxResults - 1; i++) begin
				res_q[i] <= res_q[i + 1];
			end
		end
	end

endmodule

### hw/rtl/ctt_checker.sv
// Port-level checks for the tokenizer, bound to its top level.
module ctt_checker
	import ctt_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       text_valid,
	input logic       text_ready,
	input text_beat_t text_beat,
	input logic       tok_valid,
	input logic       tok_ready,
	input tok_beat_t  tok_beat
);

	// hold a stalled result beat
	a_tok_hold: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_ready |=> tok_valid && $stable(tok_beat))
		else $error("tok beat changed while stalled");

	a_end_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && tok_beat.list_end |->
			(tok_beat.token_byte == CH_NUL) && tok_beat.run_last)
		else $error("list end is not a closing zero");

	a_final_out: assert property (@(posedge clk) disable iff (!arst_n)
		text_valid && text_ready && text_beat.final_byte |=> tok_valid)
		else $error("final byte gave no result");

	// more beats of one byte still waiting blocks new text
	a_run_block: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && !tok_beat.run_last |-> !text_ready)
		else $error("text taken while a run is unfinished");

endmodule

bind config_text_tokenizer_top ctt_checker u_ctt_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.text_valid (text_valid),
	.text_ready (text_ready),
	.text_beat  (text_beat),
	.tok_valid  (tok_valid),
	.tok_ready  (tok_ready),
	.tok_beat   (tok_beat)
);

### tb/config_text_tokenizer_top_test.sv
// Testbench for the settings text tokenizer: directed texts, random texts, checked beat by beat.
`timescale 1ns / 100ps

module config_text_tokenizer_top_test;
	import ctt_pkg::*;

	localparam logic [1:0] CM_TEXT = 2'd0;
	localparam logic [1:0] CM_LINE = 2'd1;
	localparam logic [1:0] CM_EOL  = 2'd2;

	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 6;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       text_valid;
	logic       text_ready;
	text_beat_t text_beat;
	logic       tok_valid;
	logic       tok_ready;
	tok_beat_t  tok_beat;

	// tokenizer state as predicted
	logic [1:0] pred_mode;
	logic       pred_quoted;
	logic       pred_open;

	tok_beat_t expected_tokens[$];

	int errors = 0;
	int stall_cycles = 0;
	int bytes_sent = 0;
	int texts_sent = 0;
	int tokens_checked = 0;
	int sender_idle_pct = 38;
	int receiver_idle_pct = 54;

	config_text_tokenizer_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_valid (text_valid),
		.text_ready (text_ready),
		.text_beat  (text_beat),
		.tok_valid  (tok_valid),
		.tok_ready  (tok_ready),
		.tok_beat   (tok_beat)
	);

	always #6 clk = ~clk;

	task automatic clear_tokenizer_state();
		pred_mode = CM_TEXT;
		pred_quoted = 1'b0;
		pred_open = 1'b0;
	endtask

	task automatic predict_tokens(input text_beat_t t);
		logic [7:0] c;
		logic [7:0] low;
		logic       line_end;
		logic       visible;
		tok_beat_t  batch[$];
		c = t.text_byte;
		line_end = (c == CH_CR) || (c == CH_LF);
		visible = 1'b0;
		if (pred_mode == CM_LINE) begin
			if (line_end)
				pred_mode = CM_EOL;
		end else if (pred_mode == CM_EOL && line_end) begin
			// stay in the CR/LF run after a comment
		end else begin
			pred_mode = CM_TEXT;
			if (c == CH_HASH) begin
				pred_mode = CM_LINE;
			end else if (c == CH_QUOTE) begin
				pred_quoted = !pred_quoted;
			end else begin
				low = pred_quoted ? CH_SPACE : CH_FIRST_VISIBLE;
				visible = !(c < low || c > CH_LAST_VISIBLE || c == CH_EQUALS);
			end
			if (pred_mode == CM_TEXT) begin
				if (visible) begin
					batch.push_back('{token_byte: c, list_end: 1'b0, run_last: 1'b0});
					pred_open = 1'b1;
				end else if (pred_open) begin
					batch.push_back('{token_byte: CH_NUL, list_end: 1'b0, run_last: 1'b0});
					pred_open = 1'b0;
				end
			end
		end
		if (t.final_byte) begin
			if (pred_open)
				batch.push_back('{token_byte: CH_NUL, list_end: 1'b0, run_last: 1'b0});
			batch.push_back('{token_byte: CH_NUL, list_end: 1'b1, run_last: 1'b0});
			clear_tokenizer_state();
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].run_last = 1'b1;
		foreach (batch[i])
			expected_tokens.push_back(batch[i]);
	endtask

	// predict on every accepted text beat, check every accepted token beat
	always @(posedge clk) begin
		tok_beat_t want;
		if (arst_n) begin
			if (text_valid && text_ready)
				predict_tokens(text_beat);
			if (tok_valid && tok_ready) begin
				if (expected_tokens.size() == 0) begin
					$error("unexpected token beat %h", tok_beat);
					errors++;
				end else begin
					want = expected_tokens.pop_front();
					tokens_checked++;
					if (tok_beat.token_byte !== want.token_byte) begin
						$error("token_byte: expected %h, got %h", want.token_byte,
							tok_beat.token_byte);
						errors++;
					end
					if (tok_beat.list_end !== want.list_end) begin
						$error("list_end: expected %b, got %b", want.list_end,
							tok_beat.list_end);
						errors++;
					end
					if (tok_beat.run_last !== want.run_last) begin
						$error("run_last: expected %b, got %b", want.run_last,
							tok_beat.run_last);
						errors++;
					end
				end
			end
			if ((text_valid && text_ready) || (tok_valid && tok_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
	end

	always @(negedge clk)
		tok_ready <= ($urandom_range(99) >= receiver_idle_pct);

	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("config_text_tokenizer_top_test: FAIL");
		$finish;
	end

	// entered and left at a falling edge; valid stays high for a back-to-back beat
	task automatic send_text(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < sender_idle_pct) begin
			text_valid <= 1'b0;
			@(negedge clk);
		end
		text_valid <= 1'b1;
		text_beat <= '{text_byte: b, final_byte: fin};
		do
			@(posedge clk);
		while (!text_ready);
		@(negedge clk);
		bytes_sent++;
		if (fin)
			texts_sent++;
	endtask

	// hold off text until every predicted beat has come out
	task automatic wait_for_tokens();
		text_valid <= 1'b0;
		@(negedge clk);
		while (expected_tokens.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic test_empty_text();
		send_text(CH_NUL, 1'b1);
		send_text(CH_SPACE, 1'b0);
		send_text(CH_LF, 1'b1);
		wait_for_tokens();
	endtask

	task automatic test_extremes_and_quotes();
		send_text(CH_FIRST_VISIBLE, 1'b0);
		send_text(CH_LAST_VISIBLE, 1'b0);
		send_text(8'hFF, 1'b0);
		send_text(CH_EQUALS, 1'b0);
		send_text(8'h7F, 1'b0);
		send_text(CH_QUOTE, 1'b0);
		send_text(CH_SPACE, 1'b0);
		send_text("v", 1'b0);
		send_text(CH_QUOTE, 1'b0);
		send_text(CH_SPACE, 1'b0);
		send_text("w", 1'b1);
		wait_for_tokens();
	endtask

	task automatic test_comment_endings();
		// comment inside quotes keeps quoted mode
		send_text(CH_QUOTE, 1'b0);
		send_text("a", 1'b0);
		send_text(CH_HASH, 1'b0);
		send_text("x", 1'b0);
		send_text(CH_CR, 1'b0);
		send_text(CH_LF, 1'b0);
		// a second comment right after the first
		send_text(CH_HASH, 1'b0);
		send_text(CH_LF, 1'b0);
		send_text(CH_SPACE, 1'b0);
		send_text("b", 1'b0);
		send_text(CH_QUOTE, 1'b0);
		// final byte inside a comment
		send_text(CH_HASH, 1'b0);
		send_text("y", 1'b1);
		wait_for_tokens();
	endtask

	task automatic test_open_token_at_end();
		send_text("k", 1'b1);
		wait_for_tokens();
	endtask

	function automatic logic [7:0] pick_text_byte();
		int r;
		r = $urandom_range(99);
		if (r < 55)
			return 8'($urandom_range(CH_LAST_VISIBLE, CH_FIRST_VISIBLE));
		else if (r < 65)
			return CH_SPACE;
		else if (r < 72)
			return CH_EQUALS;
		else if (r < 78)
			return CH_QUOTE;
		else if (r < 83)
			return CH_HASH;
		else if (r < 88)
			return CH_LF;
		else if (r < 92)
			return CH_CR;
		return 8'($urandom_range(255));
	endfunction

	task automatic run_random_texts(input int items, input int s_idle, input int r_idle);
		int sent;
		int len;
		// switch idle rates away from the falling edge the receiver uses
		@(posedge clk);
		sender_idle_pct = s_idle;
		receiver_idle_pct = r_idle;
		@(negedge clk);
		sent = 0;
		while (sent < items) begin
			len = ($urandom_range(9) == 0) ? $urandom_range(40, 25) : $urandom_range(12, 1);
			for (int i = 0; i < len; i++) begin
				send_text(pick_text_byte(), i == len - 1);
				sent++;
			end
		end
		wait_for_tokens();
	endtask

	initial begin
		arst_n = 1'b0;
		text_valid = 1'b0;
		text_beat = '0;
		tok_ready = 1'b0;
		clear_tokenizer_state();
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_empty_text();
		test_extremes_and_quotes();
		test_comment_endings();
		test_open_token_at_end();
		run_random_texts(60, 38, 54);
		run_random_texts(60, 54, 38);
		run_random_texts(60, 0, 0);

		if (expected_tokens.size() != 0) begin
			$error("%0d token beats never arrived", expected_tokens.size());
			errors++;
		end
		$display("Sent %0d text bytes in %0d texts; checked %0d token beats.",
			bytes_sent, texts_sent, tokens_checked);
		$display("Covered separators, quotes, comments, final bytes and three stall profiles.");
		if (errors == 0)
			$display("config_text_tokenizer_top_test: PASS");
		else
			$display("config_text_tokenizer_top_test: FAIL");
		$finish;
	end

endmodule
